[rtl/maximal_scoring_segments_macros.svh]
// Assertion macros for the maximal scoring segments block.
// Used by the port checker; no other dependencies.
`ifndef MAXIMAL_SCORING_SEGMENTS_MACROS_SVH
`define MAXIMAL_SCORING_SEGMENTS_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mss check failed");

// next-cycle implication
`define MSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mss check failed");

`endif

[rtl/mss_pkg.sv]
// Shared types and constants for the maximal scoring segments block.
// No dependencies.
`default_nettype none

package mss_pkg;

  // register index decoded from paddr[2]
  localparam logic REG_MIN_SCORE  = 1'b0;
  localparam logic REG_DROP_LIMIT = 1'b1;

  typedef struct packed {
    logic accept;
    logic run_upd;
    logic close_init;
    logic walk_act;
    logic push;
    logic xd_eval;
    logic x_apply;
    logic flush_init;
    logic flush_act;
    logic flush_seq;
    logic pos_adv;
    logic marker;
    logic release_out;
  } cmd_t;

  typedef struct packed {
    logic s_pos;
    logic fin;
    logic run_open;
    logic walk_done;
    logic need_flush;
    logic cnt_zero;
    logic flush_end;
    logic xd_cond;
    logic can_emit;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/mss_in_if.sv]
// Input stream channel: one score per transfer.
// No dependencies.
`default_nettype none

interface mss_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic               final_item;

  modport source (output valid, score, final_item, input ready);
  modport sink   (input valid, score, final_item, output ready);
endinterface

`default_nettype wire

[rtl/mss_out_if.sv]
// Result stream channel: one segment or end marker per transfer.
// No dependencies.
`default_nettype none

interface mss_out_if #(
  parameter int POS_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] seg_start;
  logic [POS_BITS-1:0] seg_end;
  logic [30:0]         seg_score;
  logic                seg_valid;
  logic                run_last;
  logic                sequence_done;

  modport source (output valid, seg_start, seg_end, seg_score, seg_valid, run_last,
                  sequence_done, input ready);
  modport sink   (input valid, seg_start, seg_end, seg_score, seg_valid, run_last,
                  sequence_done, output ready);
endinterface

`default_nettype wire

[rtl/mss_ctrl.sv]
// Sequencer for the maximal scoring segments block.
// Depends on mss_pkg (command and status structs).
`default_nettype none

module mss_ctrl import mss_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b0000_0000_0001,
    ST_DECIDE     = 12'b0000_0000_0010,
    ST_CLOSE      = 12'b0000_0000_0100,
    ST_WALK       = 12'b0000_0000_1000,
    ST_PUSH       = 12'b0000_0001_0000,
    ST_XDROP      = 12'b0000_0010_0000,
    ST_XAPPLY     = 12'b0000_0100_0000,
    ST_FINAL      = 12'b0000_1000_0000,
    ST_FLUSH_INIT = 12'b0001_0000_0000,
    ST_FLUSH_RUN  = 12'b0010_0000_0000,
    ST_MARKER     = 12'b0100_0000_0000,
    ST_WRAP       = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.s_pos) begin
          cmd_o.run_upd = 1'b1;
          state_d       = sts_i.fin ? ST_CLOSE : ST_FINAL;
        end else begin
          state_d = sts_i.run_open ? ST_CLOSE : ST_XDROP;
        end
      end
      ST_CLOSE: begin
        cmd_o.close_init = 1'b1;
        state_d          = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_act = 1'b1;
        if (sts_i.walk_done) begin
          if (sts_i.need_flush) begin
            ret_d   = ST_PUSH;
            state_d = ST_FLUSH_INIT;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_XDROP;
      end
      ST_XDROP: begin
        if (sts_i.s_pos) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.xd_eval = 1'b1;
          if (sts_i.xd_cond) begin
            ret_d   = ST_XAPPLY;
            state_d = ST_FLUSH_INIT;
          end else begin
            state_d = ST_XAPPLY;
          end
        end
      end
      ST_XAPPLY: begin
        cmd_o.x_apply = 1'b1;
        state_d       = ST_FINAL;
      end
      ST_FINAL: begin
        if (sts_i.fin) begin
          ret_d   = ST_MARKER;
          state_d = ST_FLUSH_INIT;
        end else begin
          cmd_o.pos_adv = 1'b1;
          state_d       = ST_WRAP;
        end
      end
      ST_FLUSH_INIT: begin
        if (sts_i.cnt_zero) begin
          state_d = ret_q;
        end else begin
          cmd_o.flush_init = 1'b1;
          cmd_o.flush_seq  = (ret_q == ST_MARKER);
          state_d          = ST_FLUSH_RUN;
        end
      end
      ST_FLUSH_RUN: begin
        cmd_o.flush_act = 1'b1;
        if (sts_i.flush_end) state_d = ret_q;
      end
      ST_MARKER: begin
        if (sts_i.can_emit) begin
          cmd_o.marker = 1'b1;
          state_d      = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // last result of this item leaves with run_last set
        if (!sts_i.pend_v) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.release_out = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mss_dp.sv]
// Datapath: sequence state, candidate stack memory and the result stages.
// Depends on mss_pkg (command and status structs).
`default_nettype none

module mss_dp import mss_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int POS_BITS    = 24,
  parameter int SUM_BITS    = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire signed [15:0]    score_i,
  input  wire                  final_item_i,
  input  wire [31:0]           min_score_i,
  input  wire [30:0]           drop_limit_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output logic [POS_BITS-1:0]  seg_start_o,
  output logic [POS_BITS-1:0]  seg_end_o,
  output logic [30:0]          seg_score_o,
  output logic                 seg_valid_o,
  output logic                 run_last_o,
  output logic                 sequence_done_o
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 2*POS_BITS + 2*SUM_BITS + CW;
  localparam int XW = ((SUM_BITS > 32) ? SUM_BITS : 32) + 3;
  localparam int DW = ((SUM_BITS + 2 > 33) ? SUM_BITS + 2 : 33);
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

  function automatic logic signed [SUM_BITS-1:0] sat(input logic signed [SUM_BITS:0] v);
    logic signed [SUM_BITS-1:0] r;
    if (v[SUM_BITS] != v[SUM_BITS-1]) r = v[SUM_BITS] ? SUM_MIN : SUM_MAX;
    else r = v[SUM_BITS-1:0];
    return r;
  endfunction

  logic signed [15:0]         score_q;
  logic                       fin_q;
  logic [POS_BITS-1:0]        pos_q;
  logic signed [SUM_BITS-1:0] prefix_q, rmax_q, total_q, tl_q;
  logic                       open_q;
  logic [POS_BITS-1:0]        begin_q, tb_q;
  logic [CW-1:0]              count_q, lnk_q;
  logic [IW-1:0]              j_q, i_q;
  logic                       jok_q, xd_q, fdone_q;

  logic [EW-1:0] mem [STACK_DEPTH];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] rd_addr;

  logic [POS_BITS-1:0] pend_start_q, pend_end_q;
  logic [30:0]         pend_score_q;
  logic                pend_valid_q, pend_done_q, pend_v_q;
  logic                out_v_q;

  // stack entry fields
  logic [POS_BITS-1:0]        rd_begin, rd_fin;
  logic signed [SUM_BITS-1:0] rd_left, rd_right;
  logic [CW-1:0]              rd_link;
  assign rd_begin = rd_q[EW-1 -: POS_BITS];
  assign rd_fin   = rd_q[EW-POS_BITS-1 -: POS_BITS];
  assign rd_left  = rd_q[CW+2*SUM_BITS-1 -: SUM_BITS];
  assign rd_right = rd_q[CW+SUM_BITS-1 -: SUM_BITS];
  assign rd_link  = rd_q[CW-1:0];

  logic signed [SUM_BITS:0] s_ext;
  logic                     s_pos;
  assign s_ext = {{(SUM_BITS+1-16){score_q[15]}}, score_q};
  assign s_pos = !score_q[15] && (score_q != 16'sd0);

  // candidate walk
  logic          found, merge, walk_done, need_flush, nxt_ok;
  logic [IW-1:0] nxt;
  assign found      = jok_q && (rd_left < tl_q);
  assign merge      = found && (rd_right < total_q);
  assign walk_done  = !jok_q || (found && !(rd_right < total_q));
  assign need_flush = !jok_q || (count_q >= CW'(STACK_DEPTH));

  always_comb begin
    if (!merge && rd_link != '0) begin
      nxt    = IW'(rd_link - CW'(1));
      nxt_ok = 1'b1;
    end else begin
      nxt    = j_q - IW'(1);
      nxt_ok = (j_q != '0);
    end
  end

  // flush scoring
  logic signed [DW-1:0] dx;
  logic [30:0]          d31;
  logic                 emit_need, can_emit, out_free, flush_adv, flush_last;
  assign dx = DW'(rd_right) - DW'(rd_left);
  always_comb begin
    if (dx[DW-1])            d31 = '0;
    else if (|dx[DW-2:31])   d31 = '1;
    else                     d31 = dx[30:0];
  end
  assign emit_need  = $signed({2'b00, d31}) >= $signed({min_score_i[31], min_score_i});
  assign out_free   = !out_v_q || out_ready_i;
  assign can_emit   = !pend_v_q || out_free;
  assign flush_adv  = cmd_i.flush_act && (!emit_need || can_emit);
  assign flush_last = ((CW'(i_q) + CW'(1)) == count_q);

  // x-drop test, exact
  logic signed [XW-1:0] x_lhs;
  logic                 xd_cond;
  assign x_lhs   = XW'(prefix_q) + XW'(score_q) + $signed({{(XW-31){1'b0}}, drop_limit_i});
  assign xd_cond = (drop_limit_i != '0) && (x_lhs < XW'(rmax_q));

  logic signed [SUM_BITS-1:0] x_base, run_base;
  assign x_base   = xd_q ? '0 : prefix_q;
  assign run_base = open_q ? total_q : prefix_q;

  logic [POS_BITS-1:0] en_pos;
  assign en_pos = s_pos ? pos_q + POS_BITS'(1) : pos_q;

  always_comb begin
    rd_addr = j_q;
    if (cmd_i.close_init)      rd_addr = IW'(count_q - CW'(1));
    else if (cmd_i.walk_act)   rd_addr = nxt;
    else if (cmd_i.flush_init) rd_addr = '0;
    else if (cmd_i.flush_act)  rd_addr = flush_adv ? i_q + IW'(1) : i_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[count_q[IW-1:0]] <= {tb_q, en_pos, tl_q, total_q, lnk_q};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      prefix_q <= '0;
      rmax_q   <= SUM_MIN;
      open_q   <= 1'b0;
      begin_q  <= '0;
      total_q  <= '0;
      count_q  <= '0;
      jok_q    <= 1'b0;
      j_q      <= '0;
      i_q      <= '0;
      lnk_q    <= '0;
      xd_q     <= 1'b0;
      fdone_q  <= 1'b0;
      tl_q     <= '0;
      tb_q     <= '0;
      score_q  <= '0;
      fin_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        score_q <= score_i;
        fin_q   <= final_item_i;
      end
      if (cmd_i.run_upd) begin
        if (!open_q) begin
          open_q  <= 1'b1;
          begin_q <= pos_q;
        end
        total_q <= sat({run_base[SUM_BITS-1], run_base} + s_ext);
      end
      if (cmd_i.close_init) begin
        if (total_q > rmax_q) rmax_q <= total_q;
        tl_q  <= prefix_q;
        tb_q  <= begin_q;
        jok_q <= (count_q != '0);
        j_q   <= IW'(count_q - CW'(1));
      end
      if (cmd_i.walk_act) begin
        if (!walk_done) begin
          j_q   <= nxt;
          jok_q <= nxt_ok;
          if (merge) begin
            tb_q    <= rd_begin;
            tl_q    <= rd_left;
            count_q <= CW'(j_q);
          end
        end else begin
          lnk_q <= need_flush ? '0 : CW'(j_q) + CW'(1);
        end
      end
      if (cmd_i.push) begin
        count_q  <= count_q + CW'(1);
        prefix_q <= total_q;
        open_q   <= 1'b0;
      end
      if (cmd_i.xd_eval) xd_q <= xd_cond;
      if (cmd_i.x_apply) begin
        prefix_q <= sat({x_base[SUM_BITS-1], x_base} + s_ext);
        if (xd_q) rmax_q <= SUM_MIN;
      end
      if (cmd_i.flush_init) begin
        i_q     <= '0;
        fdone_q <= cmd_i.flush_seq;
      end
      if (flush_adv) begin
        i_q <= i_q + IW'(1);
        if (flush_last) count_q <= '0;
      end
      if (cmd_i.pos_adv) pos_q <= pos_q + POS_BITS'(1);
      if (cmd_i.marker) begin
        pos_q    <= '0;
        prefix_q <= '0;
        rmax_q   <= SUM_MIN;
        open_q   <= 1'b0;
        begin_q  <= '0;
        total_q  <= '0;
        count_q  <= '0;
      end
    end
  end

  // one result waits in the pending stage until the next one shows whether it is the last
  logic                emit_flush, emit_any, load_out;
  logic [POS_BITS-1:0] new_start, new_end;
  logic [30:0]         new_score;
  logic                new_valid, new_done;
  assign emit_flush = cmd_i.flush_act && emit_need && can_emit;
  assign emit_any   = emit_flush || cmd_i.marker;
  assign load_out   = (emit_any && pend_v_q) || cmd_i.release_out;
  assign new_start  = cmd_i.marker ? '0 : rd_begin;
  assign new_end    = cmd_i.marker ? '0 : rd_fin;
  assign new_score  = cmd_i.marker ? '0 : d31;
  assign new_valid  = !cmd_i.marker;
  assign new_done   = cmd_i.marker || fdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (emit_any)               pend_v_q <= 1'b1;
      else if (cmd_i.release_out) pend_v_q <= 1'b0;
      if (load_out)               out_v_q <= 1'b1;
      else if (out_ready_i)       out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      pend_start_q <= new_start;
      pend_end_q   <= new_end;
      pend_score_q <= new_score;
      pend_valid_q <= new_valid;
      pend_done_q  <= new_done;
    end
    if (load_out) begin
      seg_start_o     <= pend_start_q;
      seg_end_o       <= pend_end_q;
      seg_score_o     <= pend_score_q;
      seg_valid_o     <= pend_valid_q;
      sequence_done_o <= pend_done_q;
      run_last_o      <= cmd_i.release_out;
    end
  end

  assign out_valid_o = out_v_q;

  always_comb begin
    sts_o            = '0;
    sts_o.s_pos      = s_pos;
    sts_o.fin        = fin_q;
    sts_o.run_open   = open_q;
    sts_o.walk_done  = walk_done;
    sts_o.need_flush = need_flush;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.flush_end  = flush_adv && flush_last;
    sts_o.xd_cond    = xd_cond;
    sts_o.can_emit   = can_emit;
    sts_o.pend_v     = pend_v_q;
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

[rtl/maximal_scoring_segments.sv]
// Maximal scoring segments over a stream of signed Q8.8 scores.
// One score per input transfer on in_i; final_item closes the sequence.
// Each result transfer on out_o carries a segment (seg_valid 1) or, after a
// final item, an end marker (seg_valid 0, sequence_done 1). run_last flags
// the last result caused by an input; an input may cause no result at all.
// One item at a time. A positive score passes the decide, final and wrap
// steps, a non-positive one the x-drop steps as well. Closing a run adds the
// close, walk and push steps, the walk visiting candidates one by one; a
// flush reads the stack entries one by one, and the end marker comes after
// it. All of this is set by the single read port of the candidate stack
// memory. A result waits in the pending stage, then goes to the output stage
// once the next result or the end of the item shows whether run_last is set.
// If out_o stalls, the block holds in the current step; two results are
// buffered (pending and output stage). Reset clears the sequence state and
// the registers (min_score, drop_limit); the stack memory needs no clearing.
// The user writes the registers over the APB port at 0 (min_score) and 4
// (drop_limit) while the block is idle; the block does not enforce this.
// Depends on mss_pkg, mss_in_if, mss_out_if, mss_ctrl, mss_dp.
`default_nettype none

module maximal_scoring_segments import mss_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int POS_BITS    = 24,
  parameter int SUM_BITS    = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mss_in_if.sink      in_i,
  mss_out_if.source   out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] min_score_q;
  logic [30:0] drop_limit_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DROP_LIMIT) ? {1'b0, drop_limit_q} : min_score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q  <= '0;
      drop_limit_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MIN_SCORE:  min_score_q  <= pwdata;
        REG_DROP_LIMIT: drop_limit_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mss_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_BITS    (POS_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .score_i         (in_i.score),
    .final_item_i    (in_i.final_item),
    .min_score_i     (min_score_q),
    .drop_limit_i    (drop_limit_q),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .seg_start_o     (out_o.seg_start),
    .seg_end_o       (out_o.seg_end),
    .seg_score_o     (out_o.seg_score),
    .seg_valid_o     (out_o.seg_valid),
    .run_last_o      (out_o.run_last),
    .sequence_done_o (out_o.sequence_done)
  );

endmodule

`default_nettype wire

[rtl/mss_chk.sv]
// Port-level checker for maximal_scoring_segments, attached by bind.
// Depends on maximal_scoring_segments_macros.svh.
`default_nettype none
`include "maximal_scoring_segments_macros.svh"

module mss_chk #(
  parameter int POS_BITS = 24
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire [POS_BITS-1:0] seg_start,
  input wire [POS_BITS-1:0] seg_end,
  input wire [30:0]         seg_score,
  input wire                seg_valid,
  input wire                run_last,
  input wire                sequence_done
);

  // a stalled result keeps its payload
  `MSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(seg_start) && $stable(seg_end) && $stable(seg_score) && $stable(seg_valid))

  // end marker is all zero and closes both the item and the sequence
  `MSS_ASSERT_NOW(a_marker, clk_i, rst_ni, out_valid && !seg_valid,
    seg_start == '0 && seg_end == '0 && seg_score == '0 && sequence_done && run_last)

  // one item at a time: no transfer right after another
  `MSS_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid && in_ready, !in_ready)

endmodule

bind maximal_scoring_segments mss_chk #(.POS_BITS(POS_BITS)) u_mss_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .seg_start     (out_o.seg_start),
  .seg_end       (out_o.seg_end),
  .seg_score     (out_o.seg_score),
  .seg_valid     (out_o.seg_valid),
  .run_last      (out_o.run_last),
  .sequence_done (out_o.sequence_done)
);

`default_nettype wire

[dv/maximal_scoring_segments_tb.sv]
// Self-checking testbench for maximal_scoring_segments: drives scores over the
// input channel and checks every segment result against an in-bench predictor.
// Depends on mss_pkg, mss_in_if, mss_out_if and the block under test.
`default_nettype none

module maximal_scoring_segments_tb;
  import mss_pkg::*;

  localparam int  DEPTH     = 32;
  localparam int  CAP       = DEPTH + 2;
  localparam longint SUMMAX = 64'sd2147483647;
  localparam longint SUMMIN = -64'sd2147483648;
  localparam longint LIMIT  = 3000000;

  typedef struct {
    logic [23:0] seg_start;
    logic [23:0] seg_end;
    logic [30:0] seg_score;
    logic        seg_valid;
    logic        run_last;
    logic        sequence_done;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mss_in_if in_ch ();
  mss_out_if #(.POS_BITS(24)) out_ch ();

  maximal_scoring_segments u_dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  longint      min_sc, drop_lim;
  logic [23:0] pos, run_beg;
  longint      psum, rmax, rtotal;
  bit          run_open;
  logic [23:0] cand_beg [DEPTH];
  logic [23:0] cand_fin [DEPTH];
  longint      cand_left [DEPTH];
  longint      cand_right [DEPTH];
  int          cand_link [DEPTH];
  int          cand_cnt;
  segment_t    step_q[$];
  segment_t    segments_due[$];

  int  errors = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_off = 0;
  longint cycles = 0;

  function automatic longint sat(longint v);
    if (v > SUMMAX) return SUMMAX;
    if (v < SUMMIN) return SUMMIN;
    return v;
  endfunction

  function automatic void add_segment(logic [23:0] st, logic [23:0] en, longint sc,
                                      bit vld, bit done);
    segment_t s;
    if (step_q.size() >= CAP) return;
    s.seg_start = st; s.seg_end = en; s.seg_score = sc[30:0];
    s.seg_valid = vld; s.run_last = 1'b0; s.sequence_done = done;
    step_q.push_back(s);
  endfunction

  function automatic void report_stack(bit done);
    longint d;
    for (int i = 0; i < cand_cnt; i++) begin
      d = cand_right[i] - cand_left[i];
      if (d > SUMMAX) d = SUMMAX;
      if (d < 0) d = 0;
      if (d >= min_sc) add_segment(cand_beg[i], cand_fin[i], d, 1'b1, done);
    end
    cand_cnt = 0;
  endfunction

  function automatic void merge_run(logic [23:0] en);
    longint r, tl;
    logic [23:0] tb;
    int j, tlink;
    r = rtotal; tl = psum; tb = run_beg;
    if (r > rmax) rmax = r;
    forever begin
      j = cand_cnt - 1;
      while (j >= 0) begin
        if (cand_left[j] < tl) break;
        j = (cand_link[j] != 0) ? cand_link[j] - 1 : j - 1;
      end
      if (j >= 0 && cand_right[j] < r) begin
        tb = cand_beg[j]; tl = cand_left[j]; cand_cnt = j;
        continue;
      end
      if (j < 0 || cand_cnt >= DEPTH) begin
        report_stack(1'b0);
        tlink = 0;
      end else begin
        tlink = j + 1;
      end
      cand_beg[cand_cnt] = tb; cand_fin[cand_cnt] = en;
      cand_left[cand_cnt] = tl; cand_right[cand_cnt] = r;
      cand_link[cand_cnt] = tlink;
      cand_cnt++;
      break;
    end
    psum = r;
    run_open = 1'b0;
  endfunction

  function automatic void clear_sequence();
    pos = '0; psum = 0; rmax = SUMMIN; run_open = 1'b0;
    run_beg = '0; rtotal = 0; cand_cnt = 0;
  endfunction

  function automatic void predict_segments(logic signed [15:0] score, bit fin);
    longint s;
    s = score;
    step_q.delete();
    if (s > 0) begin
      if (!run_open) begin
        run_open = 1'b1; run_beg = pos; rtotal = sat(psum + s);
      end else begin
        rtotal = sat(rtotal + s);
      end
      if (fin) merge_run(pos + 24'd1);
    end else begin
      if (run_open) merge_run(pos);
      if (drop_lim > 0 && psum + s + drop_lim < rmax) begin
        report_stack(1'b0);
        psum = 0; rmax = SUMMIN;
      end
      psum = sat(psum + s);
    end
    if (fin) begin
      report_stack(1'b1);
      add_segment('0, '0, 0, 1'b0, 1'b1);
      clear_sequence();
    end else begin
      pos = pos + 24'd1;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    foreach (step_q[i]) segments_due.push_back(step_q[i]);
  endfunction

  // ---- drivers
  initial begin
    in_ch.valid = 1'b0; in_ch.score = '0; in_ch.final_item = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    segment_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (segments_due.size() == 0) begin
        $error("unexpected result transfer start=%0d end=%0d score=%0d",
               out_ch.seg_start, out_ch.seg_end, out_ch.seg_score);
        errors++;
      end else begin
        e = segments_due.pop_front();
        if (out_ch.seg_start !== e.seg_start) begin
          $error("seg_start exp %0d got %0d", e.seg_start, out_ch.seg_start); errors++;
        end
        if (out_ch.seg_end !== e.seg_end) begin
          $error("seg_end exp %0d got %0d", e.seg_end, out_ch.seg_end); errors++;
        end
        if (out_ch.seg_score !== e.seg_score) begin
          $error("seg_score exp %0d got %0d", e.seg_score, out_ch.seg_score); errors++;
        end
        if (out_ch.seg_valid !== e.seg_valid) begin
          $error("seg_valid exp %0d got %0d", e.seg_valid, out_ch.seg_valid); errors++;
        end
        if (out_ch.run_last !== e.run_last) begin
          $error("run_last exp %0d got %0d", e.run_last, out_ch.run_last); errors++;
        end
        if (out_ch.sequence_done !== e.sequence_done) begin
          $error("sequence_done exp %0d got %0d", e.sequence_done,
                 out_ch.sequence_done);
          errors++;
        end
      end
    end
  end

  task automatic send_score(logic signed [15:0] score, bit fin);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.score <= score; in_ch.final_item <= fin;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    predict_segments(score, fin);
  endtask

  // an item without results may still walk and flush a full stack
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    wait_idle();
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (idx == REG_MIN_SCORE) min_sc = longint'($signed(value));
    else drop_lim = value[30:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_score();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(($urandom()));
      3, 4: return -16'($urandom_range(1024));
      default: return 16'($urandom_range(2048));
    endcase
  endfunction

  // ---- tests
  task automatic test_directed();
    write_reg(REG_MIN_SCORE, 32'd0);
    write_reg(REG_DROP_LIMIT, 32'd0);
    send_score(16'sd0, 1'b1);                 // empty sequence: marker only
    send_score(16'sh7fff, 1'b0);
    send_score(16'sh8000, 1'b0);
    send_score(16'sd1, 1'b0);
    send_score(-16'sd1, 1'b0);
    send_score(16'sd512, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd300, 1'b1);               // final closes an open run
    send_score(16'sd100, 1'b0);
    send_score(-16'sd50, 1'b1);               // final on non-positive
    write_reg(REG_DROP_LIMIT, 32'd256);       // x-drop flush mid-sequence
    send_score(16'sd1000, 1'b0);
    send_score(-16'sd900, 1'b0);
    send_score(-16'sd900, 1'b0);
    send_score(16'sd400, 1'b0);
    send_score(-16'sd1, 1'b1);
    write_reg(REG_DROP_LIMIT, 32'h7fffffff);
    write_reg(REG_MIN_SCORE, 32'h7fffffff);
    send_score(16'sh7fff, 1'b0);
    send_score(16'sh8000, 1'b1);
    write_reg(REG_MIN_SCORE, 32'h80000000);
    write_reg(REG_DROP_LIMIT, 32'd0);
    send_score(16'sh8000, 1'b0);
    send_score(16'sd5, 1'b1);
  endtask

  // ladder of equal peaks links every candidate; overflows the stack
  task automatic test_full_stack();
    write_reg(REG_MIN_SCORE, 32'd0);
    send_score(16'sd2560, 1'b0);
    for (int i = 0; i < 40; i++) begin
      send_score(-16'sd256, 1'b0);
      send_score(16'sd256, 1'b0);
    end
    send_score(-16'sd1, 1'b1);
  endtask

  task automatic random_sequences(int items);
    int n, len;
    n = 0;
    while (n < items) begin
      case ($urandom_range(4))
        0: write_reg(REG_MIN_SCORE, $urandom_range(2048));
        1: write_reg(REG_MIN_SCORE, $urandom());
        2: write_reg(REG_DROP_LIMIT, $urandom_range(3) == 0 ? 0 : $urandom_range(4096));
        3: write_reg(REG_DROP_LIMIT, $urandom() >> 1);
        default: ;
      endcase
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) send_score(rand_score(), i == len - 1);
      n += len;
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_MIN_SCORE, 32'd0);
    write_reg(REG_DROP_LIMIT, 32'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 30; i++) begin
      send_score(16'sd200, 1'b0);
      send_score(-16'sd300, 1'b0);
    end
    send_score(16'sd1, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    min_sc = 0; drop_lim = 0;
    clear_sequence();
    test_directed();
    test_full_stack();
    send_idle_pct = 21; recv_idle_pct = 62;
    random_sequences(25);
    send_idle_pct = 62; recv_idle_pct = 21;
    random_sequences(25);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_sequences(25);
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
